// ===== hw/rtl/mkdk_pkg.sv =====
// Shared types, codes and constants of the Morse keyer and decoder.
`timescale 1ns / 1ps
package mkdk_pkg;

  localparam int unsigned SQUEEZE_DIVISOR = 8;
  localparam int unsigned CountW = 31;
  localparam int unsigned SqW = 12;
  localparam logic [SqW-1:0] SqueezeDiv = SqW'(SQUEEZE_DIVISOR);
  localparam logic [CountW-1:0] COUNT_MAX = 31'h7fff_ffff;
  localparam logic [CountW-1:0] STRAIGHT_UNIT = 31'h0001_0000;

  localparam logic [2:0] PH_INIT = 3'd0;
  localparam logic [2:0] PH_IDLE = 3'd1;
  localparam logic [2:0] PH_MARK = 3'd2;
  localparam logic [2:0] PH_DOT  = 3'd3;
  localparam logic [2:0] PH_DASH = 3'd4;
  localparam logic [2:0] PH_GAP  = 3'd5;

  localparam logic [1:0] ELEM_NONE = 2'd0;
  localparam logic [1:0] ELEM_DOT  = 2'd1;
  localparam logic [1:0] ELEM_DASH = 2'd2;

  localparam logic [1:0] KEYS_NONE = 2'b00;
  localparam logic [1:0] KEYS_BOTH = 2'b11;

  typedef enum logic [7:0] {
    REG_PADDLE_MODE  = 8'd0,
    REG_KEYER_UNIT   = 8'd1,
    REG_SHOW_ELEM    = 8'd2,
    REG_AUTO_NEWLINE = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic dot_key;
    logic dash_key;
    logic restart;
  } in_t;

  typedef struct packed {
    logic        tone_on;
    logic [1:0]  element_done;
    logic        char_valid;
    logic [31:0] code_word;
    logic        word_space;
    logic        line_break;
  } res_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic       paddle_mode;
    logic [9:0] keyer_unit;
    logic       show_elements;
    logic [6:0] auto_newline_units;
  } cfg_t;

  typedef struct packed {
    logic              commit;
    logic [CountW-1:0] sample;
  } avg_req_t;

endpackage

// ===== hw/rtl/mkdk_if.sv =====
// Valid/ready channel interfaces for tick items, results and register writes.
`timescale 1ns / 1ps
interface mkdk_in_if;
  logic           valid;
  logic           ready;
  mkdk_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mkdk_res_if;
  logic           valid;
  logic           ready;
  mkdk_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mkdk_cfg_if;
  logic              valid;
  logic              ready;
  mkdk_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mkdk_cfg_regs.sv =====
// Configuration register file written over the register channel.
`timescale 1ns / 1ps
module mkdk_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  mkdk_cfg_if.sink      cfg_i,
  output mkdk_pkg::cfg_t cfg_o
);
  import mkdk_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.paddle_mode        <= 1'b0;
      cfg_q.keyer_unit         <= 10'd6;
      cfg_q.show_elements      <= 1'b0;
      cfg_q.auto_newline_units <= 7'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_PADDLE_MODE:  cfg_q.paddle_mode        <= cfg_i.data.wdata[0];
        REG_KEYER_UNIT:   cfg_q.keyer_unit         <= cfg_i.data.wdata[9:0];
        REG_SHOW_ELEM:    cfg_q.show_elements      <= cfg_i.data.wdata[0];
        REG_AUTO_NEWLINE: cfg_q.auto_newline_units <= cfg_i.data.wdata[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mkdk_avg.sv =====
// Four-entry moving average of unit length with a running sum.
`timescale 1ns / 1ps
module mkdk_avg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mkdk_pkg::avg_req_t      req_i,
  output logic [mkdk_pkg::CountW-1:0] avg_o
);
  import mkdk_pkg::*;

  logic [CountW-1:0] ring_q [4];
  logic [CountW+1:0] sum_q, sum_d;
  logic [1:0]        ptr_q, ptr_d;
  logic              primed_q;

  assign ptr_d = ptr_q - 2'd1;

  always_comb begin
    if (primed_q) begin
      sum_d = sum_q - {2'b00, ring_q[ptr_d]} + {2'b00, req_i.sample};
      avg_o = sum_d[CountW+1:2];
    end else begin
      sum_d = {req_i.sample, 2'b00};
      avg_o = req_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= 2'd0;
      primed_q <= 1'b0;
    end else if (req_i.commit) begin
      primed_q <= 1'b1;
      ptr_q    <= primed_q ? ptr_d : 2'd3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.commit) begin
      sum_q <= sum_d;
      if (primed_q) begin
        ring_q[ptr_d] <= req_i.sample;
      end else begin
        for (int i = 0; i < 4; i++) begin
          ring_q[i] <= req_i.sample;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mkdk_core.sv =====
// Keying state machine: timing, squeeze memory, element packing and gap events.
`timescale 1ns / 1ps
module mkdk_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mkdk_pkg::in_t       in_i,
  input  mkdk_pkg::cfg_t      cfg_i,
  input  logic [mkdk_pkg::CountW-1:0] avg_i,
  output mkdk_pkg::avg_req_t  avg_req_o,
  output mkdk_pkg::res_t      res_o
);
  import mkdk_pkg::*;

  logic [2:0]        phase_q, phase_d, phase_cur;
  logic [CountW-1:0] tick_q, tick_d, tick_inc;
  logic [CountW-2:0] quot_q, quot_d, quot_inc;
  logic [1:0]        rem_q, rem_d, rem_inc;
  logic [CountW-1:0] unit_q, unit_d;
  logic [1:0]        prev_q, prev_d, kmem_q, kmem_d, keys, kind;
  logic [SqW-1:0]    dsq_q, dsq_d, hsq_q, hsq_d;
  logic [SqW-1:0]    ku12, ku3, dsq_raw, hsq_raw;
  logic [13:0]       ku10;
  logic [31:0]       code_q, code_d;
  logic [CountW:0]   u2;
  logic [CountW+1:0] u3;
  logic [CountW+2:0] u5;
  logic [CountW+6:0] uline;
  logic              commit;
  res_t              res;

  assign keys = {in_i.dash_key, in_i.dot_key};
  assign phase_cur = in_i.restart ? PH_INIT : phase_q;

  always_comb begin
    if (tick_q != COUNT_MAX) begin
      tick_inc = tick_q + 31'd1;
      if (rem_q == 2'd2) begin
        quot_inc = quot_q + 30'd1;
        rem_inc  = 2'd0;
      end else begin
        quot_inc = quot_q;
        rem_inc  = rem_q + 2'd1;
      end
    end else begin
      tick_inc = tick_q;
      quot_inc = quot_q;
      rem_inc  = rem_q;
    end
  end

  assign u2    = {unit_q, 1'b0};
  assign u3    = {2'b00, unit_q} + {1'b0, unit_q, 1'b0};
  assign u5    = {3'b000, unit_q} + {1'b0, unit_q, 2'b00};
  assign uline = {7'd0, unit_q} * {31'd0, cfg_i.auto_newline_units};

  assign ku12    = {2'b00, cfg_i.keyer_unit};
  assign ku3     = ku12 + {ku12[SqW-2:0], 1'b0};
  assign ku10    = {1'b0, cfg_i.keyer_unit, 3'b000} + {3'b000, cfg_i.keyer_unit, 1'b0};
  assign dsq_raw = ku12 / SqueezeDiv;
  assign hsq_raw = ku3 / SqueezeDiv;

  always_comb begin
    phase_d = phase_cur;
    tick_d  = tick_inc;
    quot_d  = quot_inc;
    rem_d   = rem_inc;
    unit_d  = unit_q;
    prev_d  = keys;
    kmem_d  = kmem_q | ((keys ^ prev_q) & keys);
    dsq_d   = dsq_q;
    hsq_d   = hsq_q;
    code_d  = code_q;
    commit  = 1'b0;
    kind    = ELEM_DOT;
    res     = '0;
    avg_req_o.sample = tick_inc;

    unique case (phase_cur)
      PH_IDLE: begin
        if (cfg_i.paddle_mode && ((kmem_d | keys) != KEYS_NONE)) begin
          tick_d = '0;
          quot_d = '0;
          rem_d  = '0;
          if (kmem_d[0] || (!kmem_d[1] && keys[0])) begin
            code_d  = {code_q[29:0], ELEM_DOT};
            phase_d = PH_DOT;
          end else begin
            code_d  = {code_q[29:0], ELEM_DASH};
            phase_d = PH_DASH;
          end
        end else if (!cfg_i.paddle_mode && (keys != KEYS_NONE)) begin
          if (tick_inc <= unit_q) begin
            commit = 1'b1;
            unit_d = avg_i;
          end
          tick_d  = '0;
          quot_d  = '0;
          rem_d   = '0;
          phase_d = PH_MARK;
        end else begin
          if (({1'b0, tick_inc} == u2) && !cfg_i.show_elements) begin
            if (code_q != '0) begin
              res.char_valid = 1'b1;
              res.code_word  = code_q;
            end
            code_d = '0;
          end
          res.word_space = ({3'b000, tick_inc} == u5);
          res.line_break = (cfg_i.auto_newline_units != '0) && ({7'd0, tick_inc} == uline);
        end
      end
      PH_MARK: begin
        if (keys == KEYS_NONE) begin
          if ({1'b0, quot_inc} > unit_q) begin
            commit = 1'b1;
            avg_req_o.sample = {1'b0, quot_inc};
            unit_d = avg_i;
          end
          kind   = ({1'b0, tick_inc} > {unit_d, 1'b0}) ? ELEM_DASH : ELEM_DOT;
          code_d = {code_q[29:0], kind};
          if (cfg_i.show_elements) begin
            res.element_done = kind;
          end
          tick_d  = '0;
          quot_d  = '0;
          rem_d   = '0;
          phase_d = PH_IDLE;
        end
      end
      PH_DOT: begin
        if (tick_inc == {{(CountW-SqW){1'b0}}, dsq_q}) begin
          if (keys == KEYS_BOTH) begin
            kmem_d[1] = 1'b1;
          end
        end else if (tick_inc >= unit_q) begin
          kmem_d[0] = 1'b0;
          tick_d    = '0;
          quot_d    = '0;
          rem_d     = '0;
          phase_d   = PH_GAP;
          if (cfg_i.show_elements) begin
            res.element_done = ELEM_DOT;
          end
        end
      end
      PH_DASH: begin
        if (tick_inc == {{(CountW-SqW){1'b0}}, hsq_q}) begin
          if (keys == KEYS_BOTH) begin
            kmem_d[0] = 1'b1;
          end
        end else if ({2'b00, tick_inc} >= u3) begin
          kmem_d[1] = 1'b0;
          tick_d    = '0;
          quot_d    = '0;
          rem_d     = '0;
          phase_d   = PH_GAP;
          if (cfg_i.show_elements) begin
            res.element_done = ELEM_DASH;
          end
        end
      end
      PH_GAP: begin
        if (tick_inc >= unit_q) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        if (cfg_i.paddle_mode) begin
          unit_d = {{(CountW-10){1'b0}}, cfg_i.keyer_unit};
          dsq_d  = (dsq_raw == '0) ? SqW'(1) : dsq_raw;
          hsq_d  = (hsq_raw == '0) ? SqW'(1) : hsq_raw;
          tick_d = {{(CountW-14){1'b0}}, ku10};
        end else begin
          unit_d = STRAIGHT_UNIT;
          tick_d = '0;
        end
        quot_d  = '0;
        rem_d   = '0;
        code_d  = '0;
        prev_d  = KEYS_NONE;
        kmem_d  = KEYS_NONE;
        phase_d = PH_IDLE;
      end
    endcase

    res.tone_on = (phase_d == PH_MARK) || (phase_d == PH_DOT) || (phase_d == PH_DASH);
    avg_req_o.commit = commit && step_i;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INIT;
      tick_q  <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      unit_q  <= '0;
      prev_q  <= KEYS_NONE;
      kmem_q  <= KEYS_NONE;
      dsq_q   <= '0;
      hsq_q   <= '0;
      code_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
      unit_q  <= unit_d;
      prev_q  <= prev_d;
      kmem_q  <= kmem_d;
      dsq_q   <= dsq_d;
      hsq_q   <= hsq_d;
      code_q  <= code_d;
    end
  end

endmodule

// ===== hw/rtl/morse_key_decoder_keyer_top.sv =====
// Top level of the Morse keyer and decoder: handshakes and result register.
//
//   Channel  Direction  Payload                                   Transfer
//   in_i     sink       dot_key, dash_key, restart                valid && ready
//   out_o    source     tone_on, element_done, char_valid,        valid && ready
//                       code_word, word_space, line_break
//   cfg_i    sink       index, wdata                              valid (ready held high)
//
// One tick item per cycle; its result appears in the result register on the next cycle.
// The whole state update is one pass between the state registers and the result register.
// A tick is taken while the held result drains in the same cycle; ready drops only while
// a result waits and out_o.ready is low. Reset puts the keyer in its initialising phase.
`timescale 1ns / 1ps
module morse_key_decoder_keyer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mkdk_in_if.sink    in_i,
  mkdk_res_if.source out_o,
  mkdk_cfg_if.sink   cfg_i
);
  import mkdk_pkg::*;

  cfg_t              cfg;
  avg_req_t          avg_req;
  logic [CountW-1:0] avg;
  res_t              res, res_q;
  logic              res_valid_q, step;

  assign in_i.ready = !res_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  mkdk_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mkdk_avg u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (avg_req),
    .avg_o  (avg)
  );

  mkdk_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .in_i      (in_i.data),
    .cfg_i     (cfg),
    .avg_i     (avg),
    .avg_req_o (avg_req),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      res_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

endmodule

// ===== hw/rtl/mkdk_checker.sv =====
// Port-level checks of the Morse keyer and decoder, bound to its top level.
`timescale 1ns / 1ps
module mkdk_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid,
  input logic           out_ready,
  input mkdk_pkg::res_t out_data
);
  import mkdk_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_elem_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.element_done != 2'd3)
    else $error("undefined element code");

  a_code_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data.char_valid == (out_data.code_word != '0)))
    else $error("code word does not match character flag");

  a_elem_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_data.element_done != ELEM_NONE) |-> !out_data.tone_on)
    else $error("tone on after a finished element");

  a_elem_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_data.char_valid && (out_data.element_done != ELEM_NONE)))
    else $error("element and character reported together");

endmodule

bind morse_key_decoder_keyer_top mkdk_checker u_mkdk_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);

// ===== verif/tb_morse_key_decoder_keyer_top.sv =====
// Self-checking testbench for the Morse keyer and decoder top level.
`timescale 1ns / 1ps
module tb_morse_key_decoder_keyer_top;
  import mkdk_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int GAP_MAX       = 15;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_TICKS   = 200;
  localparam int RESTART_ODDS  = 400;
  localparam logic [1:0] KEYS_DOT  = 2'b01;
  localparam logic [1:0] KEYS_DASH = 2'b10;

  class keyer_scoreboard;
    bit          paddle_mode;
    logic [9:0]  keyer_unit;
    bit          show_elements;
    logic [6:0]  newline_units;

    logic [2:0]  phase;
    logic [30:0] ticks;
    logic [30:0] unit_len;
    logic [1:0]  prev_keys;
    logic [1:0]  key_mem;
    logic [30:0] dot_squeeze;
    logic [30:0] dash_squeeze;
    logic [31:0] code;
    logic [30:0] ring [4];
    logic [1:0]  ring_ptr;
    bit          ring_full;

    res_t        awaited_results[$];
    int          n_fail;
    int          n_results;

    function new();
      paddle_mode = 1'b0;
      keyer_unit = 10'd6;
      show_elements = 1'b0;
      newline_units = '0;
      phase = PH_INIT;
      ticks = '0;
      unit_len = '0;
      prev_keys = '0;
      key_mem = '0;
      dot_squeeze = '0;
      dash_squeeze = '0;
      code = '0;
      foreach (ring[i]) ring[i] = '0;
      ring_ptr = '0;
      ring_full = 1'b0;
      n_fail = 0;
      n_results = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_PADDLE_MODE:  paddle_mode = value[0];
        REG_KEYER_UNIT:   keyer_unit = value[9:0];
        REG_SHOW_ELEM:    show_elements = value[0];
        REG_AUTO_NEWLINE: newline_units = value[6:0];
        default: ;
      endcase
    endfunction

    function logic [30:0] moving_average(logic [30:0] sample);
      logic [32:0] sum;
      sum = '0;
      if (!ring_full) begin
        foreach (ring[i]) ring[i] = sample;
        ring_full = 1'b1;
        ring_ptr = 2'd3;
      end else begin
        ring_ptr = ring_ptr - 2'd1;
        ring[ring_ptr] = sample;
      end
      foreach (ring[i]) sum = sum + 33'(ring[i]);
      return sum[32:2];
    endfunction

    function void predict_tick(in_t item);
      logic [1:0]        keys;
      logic [1:0]        elem;
      logic [1:0]        kind;
      logic              spacing;
      logic [30:0]       third;
      longint unsigned   u;
      longint unsigned   tl;
      longint unsigned   lu;
      res_t              r;
      keys = {item.dash_key, item.dot_key};
      elem = ELEM_NONE;
      spacing = 1'b0;
      r = '0;
      if (item.restart) phase = PH_INIT;
      key_mem = key_mem | ((keys ^ prev_keys) & keys);
      prev_keys = keys;
      if (ticks < COUNT_MAX) ticks = ticks + 31'd1;
      u = unit_len;
      tl = ticks;
      case (phase)
        PH_IDLE: begin
          if (paddle_mode) begin
            if ((key_mem | keys) != KEYS_NONE) begin
              ticks = '0;
              code = code << 2;
              if (key_mem[0] || (!key_mem[1] && keys[0])) begin
                code = code + 32'(ELEM_DOT);
                phase = PH_DOT;
              end else begin
                code = code + 32'(ELEM_DASH);
                phase = PH_DASH;
              end
            end else begin
              spacing = 1'b1;
            end
          end else if (keys != KEYS_NONE) begin
            if (ticks <= unit_len) unit_len = moving_average(ticks);
            ticks = '0;
            phase = PH_MARK;
          end else begin
            spacing = 1'b1;
          end
          if (spacing) begin
            if (tl == 2 * u && !show_elements) begin
              if (code != '0) begin
                r.char_valid = 1'b1;
                r.code_word = code;
              end
              code = '0;
            end
            if (tl == 5 * u) r.word_space = 1'b1;
            if (newline_units != '0 && tl == u * newline_units) r.line_break = 1'b1;
          end
        end
        PH_MARK: begin
          if (keys == KEYS_NONE) begin
            third = ticks / 31'd3;
            if (third > unit_len) unit_len = moving_average(third);
            lu = unit_len;
            kind = (tl > 2 * lu) ? ELEM_DASH : ELEM_DOT;
            code = (code << 2) + 32'(kind);
            if (show_elements) elem = kind;
            ticks = '0;
            phase = PH_IDLE;
          end
        end
        PH_DOT: begin
          if (ticks == dot_squeeze) begin
            if (keys == KEYS_BOTH) key_mem[1] = 1'b1;
          end else if (tl >= u) begin
            key_mem[0] = 1'b0;
            ticks = '0;
            phase = PH_GAP;
            if (show_elements) elem = ELEM_DOT;
          end
        end
        PH_DASH: begin
          if (ticks == dash_squeeze) begin
            if (keys == KEYS_BOTH) key_mem[0] = 1'b1;
          end else if (tl >= 3 * u) begin
            key_mem[1] = 1'b0;
            ticks = '0;
            phase = PH_GAP;
            if (show_elements) elem = ELEM_DASH;
          end
        end
        PH_GAP: begin
          if (tl >= u) phase = PH_IDLE;
        end
        default: begin
          if (paddle_mode) begin
            unit_len = 31'(keyer_unit);
            dot_squeeze = unit_len / 31'(SQUEEZE_DIVISOR);
            if (dot_squeeze == '0) dot_squeeze = 31'd1;
            dash_squeeze = (unit_len * 31'd3) / 31'(SQUEEZE_DIVISOR);
            if (dash_squeeze == '0) dash_squeeze = 31'd1;
            ticks = unit_len * 31'd10;
          end else begin
            unit_len = STRAIGHT_UNIT;
            ticks = '0;
          end
          code = '0;
          prev_keys = KEYS_NONE;
          key_mem = KEYS_NONE;
          phase = PH_IDLE;
        end
      endcase
      r.tone_on = (phase == PH_MARK || phase == PH_DOT || phase == PH_DASH);
      r.element_done = elem;
      awaited_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: result %0d: %s", $time, n_results, msg);
      n_fail++;
    endtask

    task check(res_t got);
      res_t want;
      n_results++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result transfer with no tick outstanding");
        return;
      end
      want = awaited_results.pop_front();
      if (got.tone_on !== want.tone_on)
        report_mismatch($sformatf("tone_on %0b, want %0b", got.tone_on, want.tone_on));
      if (got.element_done !== want.element_done)
        report_mismatch($sformatf("element_done %0d, want %0d",
                                  got.element_done, want.element_done));
      if (got.char_valid !== want.char_valid)
        report_mismatch($sformatf("char_valid %0b, want %0b", got.char_valid, want.char_valid));
      if (got.code_word !== want.code_word)
        report_mismatch($sformatf("code_word %h, want %h", got.code_word, want.code_word));
      if (got.word_space !== want.word_space)
        report_mismatch($sformatf("word_space %0b, want %0b", got.word_space, want.word_space));
      if (got.line_break !== want.line_break)
        report_mismatch($sformatf("line_break %0b, want %0b", got.line_break, want.line_break));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   tick_gap_max = 0;
  int   res_stall_max = 0;
  int   quiet_cycles = 0;
  keyer_scoreboard sb;

  mkdk_in_if  tick_if ();
  mkdk_res_if res_if ();
  mkdk_cfg_if cfg_if ();

  morse_key_decoder_keyer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int pick_idle();
    case ($urandom_range(2))
      0: return 0;
      1: return 3;
      default: return GAP_MAX;
    endcase
  endfunction

  task automatic send_tick(in_t item);
    int gap;
    gap = $urandom_range(tick_gap_max);
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.data <= item;
    do @(posedge clk_i); while (!(tick_if.valid && tick_if.ready));
    sb.predict_tick(item);
  endtask

  task automatic send_run(logic [1:0] keys, int len, int restart_odds);
    in_t item;
    for (int i = 0; i < len; i++) begin
      item.dot_key = keys[0];
      item.dash_key = keys[1];
      item.restart = (restart_odds != 0) && ($urandom_range(restart_odds - 1) == 0);
      send_tick(item);
    end
  endtask

  task automatic send_restart(logic [1:0] keys);
    in_t item;
    item.dot_key = keys[0];
    item.dash_key = keys[1];
    item.restart = 1'b1;
    send_tick(item);
  endtask

  // hold ticks until every outstanding result has drained
  task automatic pause_ticks();
    tick_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    cfg_wr_t w;
    w.index = idx;
    w.wdata = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= w;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    sb.write_reg(idx, value);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(bit paddle, logic [9:0] unit, bit show, logic [6:0] nl);
    pause_ticks();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_PADDLE_MODE, 32'(paddle));
    write_reg(REG_KEYER_UNIT, 32'(unit));
    write_reg(REG_SHOW_ELEM, 32'(show));
    write_reg(REG_AUTO_NEWLINE, 32'(nl));
  endtask

  // marks of one or three units, spaces of one, three or seven or a line length, some noise
  task automatic key_traffic(int pace, int nl, int n_items);
    int sent;
    int len;
    int r;
    logic [1:0] keys;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        keys = 2'($urandom_range(3));
        len = $urandom_range(1, 3);
        send_run(keys, len, RESTART_ODDS);
        sent += len;
      end else begin
        keys = 2'($urandom_range(1, 3));
        len = pace * (($urandom_range(3) == 0) ? 3 : 1) + $urandom_range(2) - 1;
        if (len < 1) len = 1;
        send_run(keys, len, RESTART_ODDS);
        sent += len;
        r = $urandom_range(19);
        if (r < 10) len = pace;
        else if (r < 15) len = 3 * pace;
        else if (r < 19) len = 7 * pace;
        else len = ((nl != 0) ? nl : 12) * pace + 1;
        len = len + $urandom_range(2) - 1;
        if (len < 1) len = 1;
        send_run(KEYS_NONE, len, RESTART_ODDS);
        sent += len;
      end
      if ($urandom_range(49) == 0) pause_ticks();
    end
  endtask

  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check(res_if.data);
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("morse_key_decoder_keyer_top test failed");
    $finish;
  end

  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(res_stall_max);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  initial begin
    bit         paddle;
    logic [9:0] unit;
    logic [6:0] nl;
    int         pace;
    sb = new();
    rst_ni <= 1'b0;
    tick_if.valid <= 1'b0;
    tick_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    res_if.ready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // straight key: restart, a short space, then marks of several lengths
    apply_settings(1'b0, 10'd6, 1'b0, 7'd0);
    send_restart(KEYS_BOTH);
    send_run(KEYS_NONE, 9, 0);
    send_run(KEYS_BOTH, 2, 0);
    send_run(KEYS_NONE, 2, 0);
    send_run(KEYS_DASH, 7, 0);
    send_run(KEYS_NONE, 2, 0);
    send_run(KEYS_DOT, 2, 0);
    send_run(KEYS_NONE, 13, 0);

    // paddle at unit 1, squeeze both paddles
    tick_gap_max = pick_idle();
    res_stall_max = pick_idle();
    apply_settings(1'b1, 10'd1, 1'b0, 7'd100);
    send_restart(KEYS_NONE);
    send_run(KEYS_BOTH, 4, 0);
    send_run(KEYS_DOT, 1, 0);
    send_run(KEYS_NONE, 3, 0);
    send_run(KEYS_DASH, 2, 0);
    send_run(KEYS_NONE, 8, 0);

    // zero unit with element reports
    apply_settings(1'b1, 10'd0, 1'b1, 7'd1);
    send_restart(KEYS_DASH);
    send_run(KEYS_DOT, 1, 0);
    send_run(KEYS_DASH, 2, 0);
    send_run(KEYS_BOTH, 3, 0);
    send_run(KEYS_NONE, 3, 0);

    // widest unit: hold both paddles past the dot squeeze point
    tick_gap_max = 0;
    res_stall_max = 1;
    apply_settings(1'b1, 10'd1023, 1'b1, 7'd127);
    send_restart(KEYS_NONE);
    send_run(KEYS_BOTH, 130, 0);
    send_run(KEYS_NONE, 4, 0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      paddle = 1'($urandom_range(1));
      unit = ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1, 8));
      case ($urandom_range(4))
        0: nl = 7'd0;
        1: nl = 7'd100;
        default: nl = 7'($urandom_range(1, 12));
      endcase
      pace = paddle ? ((unit == 0) ? 1 : int'(unit)) : $urandom_range(2, 6);
      tick_gap_max = pick_idle();
      res_stall_max = pick_idle();
      apply_settings(paddle, unit, 1'($urandom_range(1)), nl);
      send_restart(KEYS_NONE);
      key_traffic(pace, (nl == 7'd100) ? 0 : int'(nl), PHASE_TICKS);
    end

    pause_ticks();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.n_fail == 0)
      $display("morse_key_decoder_keyer_top test passed");
    else
      $display("morse_key_decoder_keyer_top test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mkdk_pkg.sv
hw/rtl/mkdk_if.sv
hw/rtl/mkdk_cfg_regs.sv
hw/rtl/mkdk_avg.sv
hw/rtl/mkdk_core.sv
hw/rtl/morse_key_decoder_keyer_top.sv
hw/rtl/mkdk_checker.sv
verif/tb_morse_key_decoder_keyer_top.sv
